// ===== hw/rtl/imrh_pkg.sv =====
`timescale 1ns / 1ps
package imrh_pkg;

	localparam int CW = 17;
	localparam int GEOM_W = 4 * CW;
	localparam int QUEUE_DEPTH = 2;

	typedef logic signed [CW-1:0] coord_t;

	typedef enum logic [2:0] {
		MODE_CLEAR  = 3'd0,
		MODE_RECT   = 3'd1,
		MODE_CIRC   = 3'd2,
		MODE_POLY   = 3'd3,
		MODE_VERTEX = 3'd4,
		MODE_QUERY  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		KIND_RECT = 2'd0,
		KIND_CIRC = 2'd1,
		KIND_POLY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_HIT     = 2'd0,
		STATUS_DEFAULT = 2'd1,
		STATUS_NONE    = 2'd2
	} status_t;

	localparam logic REG_DEFAULT_TARGET  = 1'b0;
	localparam logic REG_DEFAULT_ENABLED = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_REVAL, ST_C1, ST_C2, ST_C3, ST_PV0, ST_VTX,
		ST_EDGE, ST_EMUL, ST_ESUM, ST_EADV, ST_PFIN, ST_RES
	} state_t;

	// Rectangles arrive already normalized: x/y hold the low corner.
	typedef struct packed {
		mode_t       mode;
		coord_t      x;
		coord_t      y;
		coord_t      x2;
		coord_t      y2;
		coord_t      r;
		logic [15:0] target;
	} cmd_t;

	typedef struct packed {
		kind_t              kind;
		logic [15:0]        target;
		logic [GEOM_W-1:0]  geom;
	} region_t;

	typedef struct packed {
		coord_t y;
		coord_t x;
	} vtx_t;

	typedef struct packed {
		logic [15:0] target;
		logic        enabled;
	} cfg_t;

endpackage

// ===== hw/rtl/imrh_queue.sv =====
`timescale 1ns / 1ps
module imrh_queue #(
	parameter int DEPTH = 2,
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [AW-1:0]   wptr_q, rptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            do_wr, do_rd;

	assign full  = (cnt_q == CNTW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

// ===== hw/rtl/imrh_front.sv =====
`timescale 1ns / 1ps
module imrh_front
	import imrh_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic        push,
	output logic        full,
	input  logic [2:0]  mode,
	input  logic [15:0] x,
	input  logic [15:0] y,
	input  logic [15:0] x_second,
	input  logic [15:0] y_second,
	input  logic [15:0] radius,
	input  logic [15:0] target_id,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_cmd
);
	localparam int SB = (COORD_BITS <= 16) ? COORD_BITS - 1 : 15;
	localparam bit SEXT = (COORD_BITS <= 16);

	// Keeps the low COORD_BITS bits and sign-extends from the top one; above 16 bits it zero-extends.
	function automatic coord_t to_coord(input logic [15:0] raw);
		logic [16:0] rx;
		coord_t      c;
		rx = {1'b0, raw};
		for (int i = 0; i < CW; i++) begin
			if (i < 16 && (i <= SB || !SEXT)) begin
				c[i] = rx[i];
			end else begin
				c[i] = SEXT ? rx[SB] : 1'b0;
			end
		end
		return c;
	endfunction

	coord_t cx, cy, cx2, cy2;
	logic   known;

	assign cx  = to_coord(x);
	assign cy  = to_coord(y);
	assign cx2 = to_coord(x_second);
	assign cy2 = to_coord(y_second);

	always_comb begin
		case (mode_t'(mode))
			MODE_CLEAR, MODE_RECT, MODE_CIRC, MODE_POLY, MODE_VERTEX, MODE_QUERY: begin
				known = 1'b1;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	always_comb begin
		q_cmd.mode   = mode_t'(mode);
		q_cmd.r      = to_coord(radius);
		q_cmd.target = target_id;
		if (mode_t'(mode) == MODE_RECT) begin
			q_cmd.x  = ($signed(cx) < $signed(cx2)) ? cx : cx2;
			q_cmd.x2 = ($signed(cx) < $signed(cx2)) ? cx2 : cx;
			q_cmd.y  = ($signed(cy) < $signed(cy2)) ? cy : cy2;
			q_cmd.y2 = ($signed(cy) < $signed(cy2)) ? cy2 : cy;
		end else begin
			q_cmd.x  = cx;
			q_cmd.y  = cy;
			q_cmd.x2 = cx2;
			q_cmd.y2 = cy2;
		end
	end

	// Unused modes are taken and dropped here.
	assign full   = q_full;
	assign q_push = push && !q_full && known;

endmodule

// ===== hw/rtl/imrh_back.sv =====
`timescale 1ns / 1ps
module imrh_back
	import imrh_pkg::*;
#(
	parameter int MAX_REGIONS = 64,
	parameter int MAX_VERTICES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_empty,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	input  cfg_t        cfg,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  status,
	output logic [15:0] hit_target,
	output logic [5:0]  hit_index,
	output logic        overflow
);
	localparam int RB  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int RCB = $clog2(MAX_REGIONS + 1);
	localparam int VB  = $clog2(MAX_VERTICES);
	localparam int VCB = $clog2(MAX_VERTICES + 1);
	localparam int DW  = CW + 1;
	localparam int PW  = 2 * DW;

	region_t reg_mem [MAX_REGIONS];
	vtx_t    vtx_mem [MAX_VERTICES];
	region_t reg_rd_q;
	vtx_t    vtx_rd_q;

	state_t state_q, state_nx;

	logic [RCB-1:0] region_count_q, ri_q, ri_nx;
	logic [VCB-1:0] vertex_count_q, vi_q, vi_nx;
	logic [VCB-1:0] open_start_q, open_n_q;
	logic [RB-1:0]  open_idx_q;
	logic [15:0]    open_tgt_q;
	logic           poly_open_q, last_valid_q, ovf_q;
	vtx_t           last_q;
	logic           out_valid_q, found_q;
	logic           pend_q, cross_q, closing_q;

	coord_t         qx_q, qy_q, pend_y_q, sec_y_q;
	vtx_t           a_q, b_q, first_q, prev_q;
	logic signed [DW-1:0] d0_q, d1_q, d2_q, d3_q;
	logic signed [PW-1:0] p0_q, p1_q;
	logic signed [PW:0]   sum_q;

	logic [1:0]  status_q;
	logic [15:0] target_q;
	logic [5:0]  index_q;
	logic        ovf_out_q;

	logic           reg_we, reg_re, vtx_we, vtx_re;
	logic [RB-1:0]  reg_waddr, reg_raddr;
	logic [VB-1:0]  vtx_raddr;
	region_t        reg_wdata;
	vtx_t           cmd_v;
	logic           reg_full, vtx_full, dup, vtx_ok, add_ok, is_add;
	logic           out_load;

	// Fields of the region read back.
	coord_t         g0, g1, g2, g3;
	logic [VCB-1:0] p_start, p_n;
	logic [VCB:0]   vsum;

	// Edge evaluation.
	coord_t ax, ay, bx, by;
	logic   e_hit, e_tog, e_pset, e_pclr, e_mul;
	logic   rect_hit, circ_hit, s_hit, s_tog, p_hit, more, need_close, last_region;
	logic signed [PW:0]   s_val;
	logic signed [DW-1:0] m0a, m0b, m1a, m1b;
	logic [RCB+5:0] idx_ext;

	assign g0 = reg_rd_q.geom[0 +: CW];
	assign g1 = reg_rd_q.geom[CW +: CW];
	assign g2 = reg_rd_q.geom[2*CW +: CW];
	assign g3 = reg_rd_q.geom[3*CW +: CW];
	assign p_start = reg_rd_q.geom[0 +: VCB];
	assign p_n     = reg_rd_q.geom[32 +: VCB];

	assign reg_full = (region_count_q == RCB'(MAX_REGIONS));
	assign vtx_full = (vertex_count_q == VCB'(MAX_VERTICES));
	assign cmd_v.x  = cmd.x;
	assign cmd_v.y  = cmd.y;
	assign dup      = last_valid_q && (last_q == cmd_v);
	assign is_add   = (cmd.mode == MODE_RECT) || (cmd.mode == MODE_CIRC) ||
	                  (cmd.mode == MODE_POLY);
	assign add_ok   = is_add && !reg_full;
	assign vtx_ok   = (cmd.mode == MODE_VERTEX) && poly_open_q && !dup && !vtx_full;
	assign cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;

	assign last_region = ((ri_q + 1'b1) == region_count_q);
	assign out_load    = (state_q == ST_RES) && (!out_valid_q || pop);

	assign ax = a_q.x;
	assign ay = a_q.y;
	assign bx = b_q.x;
	assign by = b_q.y;

	always_comb begin
		rect_hit = ($signed(g0) <= $signed(qx_q)) && ($signed(qx_q) <= $signed(g2)) &&
		           ($signed(g1) <= $signed(qy_q)) && ($signed(qy_q) <= $signed(g3));
		circ_hit = (sum_q <= (PW+1)'(p0_q));
		s_val    = (PW+1)'(p0_q) + (PW+1)'(p1_q);
		s_hit    = (s_val == '0);
		s_tog    = d1_q[DW-1] ? (s_val < 0) : (s_val > 0);
		p_hit    = cross_q ^ (pend_q &&
		           (($signed(pend_y_q) < $signed(by) && $signed(by) < $signed(sec_y_q)) ||
		            ($signed(pend_y_q) > $signed(by) && $signed(by) > $signed(sec_y_q))));
		more       = ({1'b0, vi_q} + 1'b1) < {1'b0, p_n};
		need_close = !closing_q && (prev_q != first_q);
	end

	always_comb begin
		e_hit  = 1'b0;
		e_tog  = 1'b0;
		e_pset = 1'b0;
		e_pclr = 1'b0;
		e_mul  = 1'b0;
		if (qx_q == ax && qy_q == ay) begin
			e_hit = 1'b1;
		end else if (ay == by) begin
			e_hit = (qy_q == ay) &&
			        (($signed(ax) <= $signed(qx_q) && $signed(qx_q) <= $signed(bx)) ||
			         ($signed(ax) >= $signed(qx_q) && $signed(qx_q) >= $signed(bx)));
		end else if (pend_q) begin
			e_tog  = ($signed(pend_y_q) < $signed(ay) && $signed(ay) < $signed(by)) ||
			         ($signed(pend_y_q) > $signed(ay) && $signed(ay) > $signed(by));
			e_pclr = 1'b1;
		end else if ($signed(qy_q) >= (($signed(ay) < $signed(by)) ? $signed(ay) : $signed(by)) &&
		             $signed(qy_q) <= (($signed(ay) < $signed(by)) ? $signed(by) : $signed(ay)) &&
		             $signed(qx_q) <= (($signed(ax) < $signed(bx)) ? $signed(bx) : $signed(ax))) begin
			if (ax == bx) begin
				e_hit = (ax == qx_q);
				e_tog = $signed(ax) > $signed(qx_q);
			end else if (qy_q == by) begin
				e_pset = 1'b1;
			end else begin
				e_mul = 1'b1;
			end
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty && cmd.mode == MODE_QUERY) begin
					state_nx = (region_count_q == '0) ? ST_RES : ST_REVAL;
				end
			end
			ST_REVAL: begin
				case (reg_rd_q.kind)
					KIND_RECT: begin
						state_nx = rect_hit ? ST_RES : (last_region ? ST_RES : ST_REVAL);
					end
					KIND_CIRC: begin
						state_nx = ST_C1;
					end
					KIND_POLY: begin
						state_nx = (p_n < VCB'(2)) ? (last_region ? ST_RES : ST_REVAL) : ST_PV0;
					end
					default: begin
						state_nx = last_region ? ST_RES : ST_REVAL;
					end
				endcase
			end
			ST_C1: state_nx = ST_C2;
			ST_C2: state_nx = ST_C3;
			ST_C3: state_nx = circ_hit ? ST_RES : (last_region ? ST_RES : ST_REVAL);
			ST_PV0: state_nx = ST_VTX;
			ST_VTX: state_nx = ST_EDGE;
			ST_EDGE: state_nx = e_hit ? ST_RES : (e_mul ? ST_EMUL : ST_EADV);
			ST_EMUL: state_nx = ST_ESUM;
			ST_ESUM: state_nx = s_hit ? ST_RES : ST_EADV;
			ST_EADV: state_nx = more ? ST_VTX : (need_close ? ST_EDGE : ST_PFIN);
			ST_PFIN: state_nx = p_hit ? ST_RES : (last_region ? ST_RES : ST_REVAL);
			ST_RES: state_nx = out_load ? ST_IDLE : ST_RES;
			default: state_nx = ST_IDLE;
		endcase
	end

	// Memory ports and counters that follow the next state.
	always_comb begin
		ri_nx = ri_q;
		if (state_q == ST_IDLE) begin
			ri_nx = '0;
		end else if (state_nx == ST_REVAL) begin
			ri_nx = ri_q + 1'b1;
		end
		vi_nx = vi_q;
		if (state_nx == ST_PV0) begin
			vi_nx = '0;
		end else if (state_nx == ST_VTX) begin
			vi_nx = vi_q + 1'b1;
		end
		reg_re    = (state_nx == ST_REVAL);
		reg_raddr = ri_nx[RB-1:0];
		vtx_re    = (state_nx == ST_PV0) || (state_nx == ST_VTX);
		vsum      = {1'b0, p_start} + {1'b0, vi_nx};
		vtx_raddr = vsum[VB-1:0];

		vtx_we    = cmd_pop && vtx_ok;
		reg_we    = cmd_pop && (add_ok || vtx_ok);
		reg_waddr = vtx_ok ? open_idx_q : region_count_q[RB-1:0];
		reg_wdata = '0;
		if (vtx_ok) begin
			reg_wdata.kind   = KIND_POLY;
			reg_wdata.target = open_tgt_q;
			reg_wdata.geom[0 +: VCB]  = open_start_q;
			reg_wdata.geom[32 +: VCB] = open_n_q + 1'b1;
		end else begin
			reg_wdata.target = cmd.target;
			case (cmd.mode)
				MODE_RECT: begin
					reg_wdata.kind = KIND_RECT;
					reg_wdata.geom = {cmd.y2, cmd.x2, cmd.y, cmd.x};
				end
				MODE_CIRC: begin
					reg_wdata.kind = KIND_CIRC;
					reg_wdata.geom[0 +: 3*CW] = {cmd.r, cmd.y, cmd.x};
				end
				default: begin
					reg_wdata.kind = KIND_POLY;
					reg_wdata.geom[0 +: VCB] = vertex_count_q;
				end
			endcase
		end

		m0a = (state_q == ST_C2) ? DW'(g2) : d0_q;
		m0b = (state_q == ST_C2) ? DW'(g2) : ((state_q == ST_C1) ? d0_q : d1_q);
		m1a = (state_q == ST_C1) ? d1_q : d2_q;
		m1b = (state_q == ST_C1) ? d1_q : d3_q;
	end

	always_ff @(posedge clk) begin
		if (reg_we) begin
			reg_mem[reg_waddr] <= reg_wdata;
		end
		if (reg_re) begin
			reg_rd_q <= reg_mem[reg_raddr];
		end
		if (vtx_we) begin
			vtx_mem[vertex_count_q[VB-1:0]] <= cmd_v;
		end
		if (vtx_re) begin
			vtx_rd_q <= vtx_mem[vtx_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			region_count_q <= '0;
			vertex_count_q <= '0;
			poly_open_q    <= 1'b0;
			last_valid_q   <= 1'b0;
			ovf_q          <= 1'b0;
			out_valid_q    <= 1'b0;
			found_q        <= 1'b0;
			pend_q         <= 1'b0;
			cross_q        <= 1'b0;
			closing_q      <= 1'b0;
			ri_q           <= '0;
			vi_q           <= '0;
			open_n_q       <= '0;
		end else begin
			state_q <= state_nx;
			ri_q    <= ri_nx;
			vi_q    <= vi_nx;
			if (cmd_pop) begin
				case (cmd.mode)
					MODE_CLEAR: begin
						region_count_q <= '0;
						vertex_count_q <= '0;
						poly_open_q    <= 1'b0;
						last_valid_q   <= 1'b0;
						ovf_q          <= 1'b0;
					end
					MODE_RECT, MODE_CIRC, MODE_POLY: begin
						poly_open_q  <= (cmd.mode == MODE_POLY) && !reg_full;
						last_valid_q <= 1'b0;
						open_n_q     <= '0;
						if (reg_full) begin
							ovf_q <= 1'b1;
						end else begin
							region_count_q <= region_count_q + 1'b1;
						end
					end
					MODE_VERTEX: begin
						if (poly_open_q && !dup) begin
							if (vtx_full) begin
								ovf_q <= 1'b1;
							end else begin
								vertex_count_q <= vertex_count_q + 1'b1;
								last_valid_q   <= 1'b1;
								open_n_q       <= open_n_q + 1'b1;
							end
						end
					end
					MODE_QUERY: begin
						found_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_REVAL: begin
					if (reg_rd_q.kind == KIND_RECT && rect_hit) begin
						found_q <= 1'b1;
					end
				end
				ST_C3: begin
					if (circ_hit) begin
						found_q <= 1'b1;
					end
				end
				ST_PV0: begin
					pend_q    <= 1'b0;
					cross_q   <= 1'b0;
					closing_q <= 1'b0;
				end
				ST_EDGE: begin
					if (e_hit) begin
						found_q <= 1'b1;
					end
					if (e_pset) begin
						pend_q <= 1'b1;
					end else if (e_pclr) begin
						pend_q <= 1'b0;
					end
					cross_q <= cross_q ^ e_tog;
				end
				ST_ESUM: begin
					if (s_hit) begin
						found_q <= 1'b1;
					end
					cross_q <= cross_q ^ s_tog;
				end
				ST_EADV: begin
					if (!more && need_close) begin
						closing_q <= 1'b1;
					end
				end
				ST_PFIN: begin
					if (p_hit) begin
						found_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign idx_ext = {6'd0, ri_q};

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			qx_q <= cmd.x;
			qy_q <= cmd.y;
			if (cmd.mode == MODE_POLY) begin
				open_idx_q   <= region_count_q[RB-1:0];
				open_start_q <= vertex_count_q;
				open_tgt_q   <= cmd.target;
			end
			if (vtx_ok) begin
				last_q <= cmd_v;
			end
		end
		case (state_q)
			ST_REVAL: begin
				d0_q <= DW'(g0) - DW'(qx_q);
				d1_q <= DW'(g1) - DW'(qy_q);
			end
			ST_C1, ST_EMUL: begin
				p0_q <= m0a * m0b;
				p1_q <= m1a * m1b;
			end
			ST_C2: begin
				sum_q <= (PW+1)'(p0_q) + (PW+1)'(p1_q);
				p0_q  <= m0a * m0b;
			end
			ST_PV0: begin
				first_q <= vtx_rd_q;
				prev_q  <= vtx_rd_q;
			end
			ST_VTX: begin
				a_q    <= prev_q;
				b_q    <= vtx_rd_q;
				prev_q <= vtx_rd_q;
				if (vi_q == VCB'(1)) begin
					sec_y_q <= vtx_rd_q.y;
				end
			end
			ST_EDGE: begin
				d0_q <= DW'(ax) - DW'(qx_q);
				d1_q <= DW'(by) - DW'(ay);
				d2_q <= DW'(qy_q) - DW'(ay);
				d3_q <= DW'(bx) - DW'(ax);
				if (e_pset) begin
					pend_y_q <= ay;
				end
			end
			ST_EADV: begin
				if (!more && need_close) begin
					a_q <= prev_q;
					b_q <= first_q;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			ovf_out_q <= ovf_q;
			if (found_q) begin
				status_q <= STATUS_HIT;
				target_q <= reg_rd_q.target;
				index_q  <= idx_ext[5:0];
			end else begin
				status_q <= cfg.enabled ? STATUS_DEFAULT : STATUS_NONE;
				target_q <= cfg.enabled ? cfg.target : 16'd0;
				index_q  <= 6'd0;
			end
		end
	end

	assign empty      = !out_valid_q;
	assign status     = status_q;
	assign hit_target = target_q;
	assign hit_index  = index_q;
	assign overflow   = ovf_out_q;

endmodule

// ===== hw/rtl/image_map_region_hit_test_unit.sv =====
`timescale 1ns / 1ps
// Region hit test over a table of rectangles, circles and polygons.
// Input channel: an item is taken on a clock edge with push high and full low.
// Modes clear the table, add a rectangle or circle, open a polygon, append a
// polygon vertex, or query a point. Only queries produce a result.
// Result channel: while empty is low the oldest result is on status,
// hit_target, hit_index and overflow; pop with empty low takes it.
// Configuration: cfg_write stores cfg_data into register cfg_index
// (0 default target, 1 default enable) on the same edge.
// A two-entry command queue sits between the input decoder and the engine.
// Load items are applied as the idle engine pops them; a query holds the queue
// until its result is loaded. A query walks the table in order: setup, then each
// rectangle, each circle through its multiply steps, and for a polygon a vertex
// fetch per edge (none for the closing edge), a multiply and sum step for a
// slanted edge that needs the cross product, and a final crossing check; it stops at the first hit.
// The engine rate is set by the single read port of the region and vertex
// memories and the shared two-multiplier unit.
// When the receiver stalls, one finished result waits in the output register
// and the queue keeps taking load items; the next query waits at its end.
// Reset empties both tables, closes any polygon, clears overflow and the
// default registers; the result side comes up empty.
module image_map_region_hit_test_unit
	import imrh_pkg::*;
#(
	parameter int MAX_REGIONS = 64,
	parameter int MAX_VERTICES = 256,
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  mode,
	input  logic [15:0] x,
	input  logic [15:0] y,
	input  logic [15:0] x_second,
	input  logic [15:0] y_second,
	input  logic [15:0] radius,
	input  logic [15:0] target_id,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [15:0] hit_target,
	output logic [5:0]  hit_index,
	output logic        overflow,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	cfg_t cfg_q;
	cmd_t q_in, q_out;
	logic q_push, q_full, q_empty, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DEFAULT_TARGET:  cfg_q.target  <= cfg_data;
				REG_DEFAULT_ENABLED: cfg_q.enabled <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	imrh_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.push     (push),
		.full     (full),
		.mode     (mode),
		.x        (x),
		.y        (y),
		.x_second (x_second),
		.y_second (y_second),
		.radius   (radius),
		.target_id(target_id),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_in)
	);

	imrh_queue #(
		.DEPTH(QUEUE_DEPTH),
		.W    ($bits(cmd_t))
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_push),
		.wdata (q_in),
		.full  (q_full),
		.rd    (q_pop),
		.rdata (q_out),
		.empty (q_empty)
	);

	imrh_back #(
		.MAX_REGIONS (MAX_REGIONS),
		.MAX_VERTICES(MAX_VERTICES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (q_empty),
		.cmd       (q_out),
		.cmd_pop   (q_pop),
		.cfg       (cfg_q),
		.pop       (pop),
		.empty     (empty),
		.status    (status),
		.hit_target(hit_target),
		.hit_index (hit_index),
		.overflow  (overflow)
	);

endmodule

// ===== hw/rtl/imrh_checker.sv =====
`timescale 1ns / 1ps
module imrh_checker
	import imrh_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  status,
	input logic [15:0] hit_target,
	input logic [5:0]  hit_index
);

	// A miss never reports a table index.
	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != STATUS_HIT) |-> (hit_index == 6'd0))
		else $error("nonzero index on a miss");

	// Without a default the target reads as zero.
	a_none_target: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == STATUS_NONE) |-> (hit_target == 16'd0))
		else $error("nonzero target with no default");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == STATUS_HIT || status == STATUS_DEFAULT ||
		            status == STATUS_NONE))
		else $error("undefined status code");

	// A waiting result keeps its status and target until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(hit_target)))
		else $error("result changed while stalled");

endmodule

bind image_map_region_hit_test_unit imrh_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.status    (status),
	.hit_target(hit_target),
	.hit_index (hit_index)
);

// ===== verif/tb_image_map_region_hit_test_unit.sv =====
`timescale 1ns / 1ps
module tb_image_map_region_hit_test_unit;
	import imrh_pkg::*;

	localparam int N_REGIONS = 64;
	localparam int N_VERTICES = 256;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 60;
	localparam int RANDOM_ITEMS = 580;
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	typedef struct {
		status_t     st;
		logic [15:0] target;
		logic [5:0]  index;
		logic        ovf;
	} hit_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [2:0]  mode = '0;
	logic [15:0] x = '0;
	logic [15:0] y = '0;
	logic [15:0] x_second = '0;
	logic [15:0] y_second = '0;
	logic [15:0] radius = '0;
	logic [15:0] target_id = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  status;
	logic [15:0] hit_target;
	logic [5:0]  hit_index;
	logic        overflow;
	logic        cfg_write = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	image_map_region_hit_test_unit uut (.*);

	// Shadow copy of the region table used to predict query answers.
	kind_t       m_kind [N_REGIONS];
	logic [63:0] m_geom [N_REGIONS];
	logic [15:0] m_target [N_REGIONS];
	logic [31:0] m_vertex [N_VERTICES];
	int          m_regions = 0;
	int          m_vertices = 0;
	logic [31:0] m_last_vertex = '0;
	bit          m_last_valid = 0;
	bit          m_overflow = 0;
	bit          m_poly_open = 0;
	logic [15:0] m_dflt_target = '0;
	bit          m_dflt_enabled = 0;

	hit_result_t pending_hits [$];
	int errors = 0;
	int checked = 0;
	int hits_seen = 0;
	int items_sent = 0;
	int cycles = 0;
	int burst_left = 8;
	int phases = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_image_map_region_hit_test_unit NOT OK");
			$finish;
		end
	end

	function automatic longint sx(logic [15:0] v);
		logic signed [15:0] t;
		t = v;
		return t;
	endfunction

	function automatic logic [31:0] vertex_at(int unsigned idx);
		return idx < N_VERTICES ? m_vertex[idx] : 32'd0;
	endfunction

	function automatic bit rect_contains(logic [63:0] g, longint px, longint py);
		longint x1, y1, x2, y2;
		x1 = sx(g[15:0]);
		y1 = sx(g[31:16]);
		x2 = sx(g[47:32]);
		y2 = sx(g[63:48]);
		return (x1 < x2 ? x1 : x2) <= px && px <= (x1 < x2 ? x2 : x1) &&
			(y1 < y2 ? y1 : y2) <= py && py <= (y1 < y2 ? y2 : y1);
	endfunction

	function automatic bit inside_circle(logic [63:0] g, longint px, longint py);
		longint dx, dy, r;
		dx = sx(g[15:0]) - px;
		dy = sx(g[31:16]) - py;
		r = sx(g[47:32]);
		return dx * dx + dy * dy <= r * r;
	endfunction

	// Crossing count; a crossing that ends on a vertex is settled by the next edge.
	function automatic bit inside_polygon(logic [63:0] g, longint px, longint py);
		int unsigned first, n, m, i, crossings;
		bit pend;
		longint pend_y, ax, ay, bx, by, sy, d, s;
		logic [31:0] va, vb, vl;
		first = g[31:0];
		n = g[63:32];
		crossings = 0;
		pend = 0;
		pend_y = 0;
		if (n < 2)
			return 0;
		m = (vertex_at(first + n - 1) != vertex_at(first)) ? n + 1 : n;
		for (i = 0; i + 1 < m; i++) begin
			va = vertex_at(first + (i < n ? i : 0));
			vb = vertex_at(first + (i + 1 < n ? i + 1 : 0));
			ax = sx(va[15:0]);
			ay = sx(va[31:16]);
			bx = sx(vb[15:0]);
			by = sx(vb[31:16]);
			if (px == ax && py == ay) begin
				return 1;
			end else if (ay == by) begin
				if (py == ay && ((ax <= px && px <= bx) || (ax >= px && px >= bx)))
					return 1;
			end else if (pend) begin
				if ((pend_y < ay && ay < by) || (pend_y > ay && ay > by))
					crossings++;
				pend = 0;
			end else if (py >= (ay < by ? ay : by) && py <= (ay < by ? by : ay) &&
					px <= (ax < bx ? bx : ax)) begin
				if (ax == bx) begin
					if (ax == px)
						return 1;
					if (ax > px)
						crossings++;
				end else if (py == by) begin
					pend = 1;
					pend_y = ay;
				end else begin
					d = by - ay;
					s = (ax - px) * d + (py - ay) * (bx - ax);
					if (d < 0)
						s = -s;
					if (s == 0)
						return 1;
					if (s > 0)
						crossings++;
				end
			end
		end
		if (pend) begin
			vl = vertex_at(first + (m - 1 < n ? m - 1 : 0));
			ay = sx(vl[31:16]);
			vl = vertex_at(first + 1);
			sy = sx(vl[31:16]);
			if ((pend_y < ay && ay < sy) || (pend_y > ay && ay > sy))
				crossings++;
		end
		return crossings[0];
	endfunction

	function automatic bit append_region(kind_t k, logic [63:0] g, logic [15:0] t);
		m_poly_open = 0;
		m_last_valid = 0;
		if (m_regions >= N_REGIONS) begin
			m_overflow = 1;
			return 0;
		end
		m_kind[m_regions] = k;
		m_geom[m_regions] = g;
		m_target[m_regions] = t;
		m_regions++;
		return 1;
	endfunction

	function automatic hit_result_t answer_query(logic [15:0] qx, logic [15:0] qy);
		hit_result_t r;
		bit hit;
		r.ovf = m_overflow;
		for (int i = 0; i < m_regions; i++) begin
			case (m_kind[i])
				KIND_RECT: hit = rect_contains(m_geom[i], sx(qx), sx(qy));
				KIND_CIRC: hit = inside_circle(m_geom[i], sx(qx), sx(qy));
				default:   hit = inside_polygon(m_geom[i], sx(qx), sx(qy));
			endcase
			if (hit) begin
				r.st = STATUS_HIT;
				r.target = m_target[i];
				r.index = i[5:0];
				return r;
			end
		end
		r.st = m_dflt_enabled ? STATUS_DEFAULT : STATUS_NONE;
		r.target = m_dflt_enabled ? m_dflt_target : 16'd0;
		r.index = '0;
		return r;
	endfunction

	// Updates the shadow table, or queues the expected result of a query, for one accepted transaction.
	task automatic apply_item(logic [2:0] md, logic [15:0] px, logic [15:0] py,
			logic [15:0] px2, logic [15:0] py2, logic [15:0] pr, logic [15:0] pt);
		case (md)
			MODE_CLEAR: begin
				m_regions = 0;
				m_vertices = 0;
				m_last_valid = 0;
				m_poly_open = 0;
				m_overflow = 0;
			end
			MODE_RECT: void'(append_region(KIND_RECT, {py2, px2, py, px}, pt));
			MODE_CIRC: void'(append_region(KIND_CIRC, {16'd0, pr, py, px}, pt));
			MODE_POLY: begin
				if (append_region(KIND_POLY, 64'(m_vertices), pt))
					m_poly_open = 1;
			end
			MODE_VERTEX: begin
				if (m_poly_open && !(m_last_valid && m_last_vertex == {py, px})) begin
					if (m_vertices >= N_VERTICES) begin
						m_overflow = 1;
					end else begin
						m_vertex[m_vertices] = {py, px};
						m_vertices++;
						m_last_vertex = {py, px};
						m_last_valid = 1;
						m_geom[m_regions - 1][63:32] += 32'd1;
					end
				end
			end
			MODE_QUERY: pending_hits.push_back(answer_query(px, py));
			default: ;
		endcase
	endtask

	task automatic send_item(logic [2:0] md, logic [15:0] px, logic [15:0] py,
			logic [15:0] px2 = 16'd0, logic [15:0] py2 = 16'd0,
			logic [15:0] pr = 16'd0, logic [15:0] pt = 16'd0);
		@(negedge clk);
		mode = md;
		x = px;
		y = py;
		x_second = px2;
		y_second = py2;
		radius = pr;
		target_id = pt;
		push = 1'b1;
		do
			@(posedge clk);
		while (full);
		apply_item(md, px, py, px2, py2, pr, pt);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			@(negedge clk);
			push = 1'b0;
			repeat ($urandom_range(0, 7)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 24);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		push = 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] data);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_write = 1'b0;
		if (idx == REG_DEFAULT_TARGET)
			m_dflt_target = data;
		else
			m_dflt_enabled = data[0];
	endtask

	// Receiver: stall behavior switches among always popping, popping at random and popping rarely.
	int stall_kind = 0;
	always @(negedge clk) begin
		if (cycles % 150 == 0)
			stall_kind = $urandom_range(0, 2);
		case (stall_kind)
			0: pop = 1'b1;
			1: pop = $urandom_range(0, 1);
			default: pop = ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		hit_result_t e;
		if (arst_n && pop && !empty) begin
			if (pending_hits.size() == 0) begin
				$display("%0t: result with nothing expected (status %0d target %0d)",
					$time, status, hit_target);
				errors++;
			end else begin
				e = pending_hits.pop_front();
				checked++;
				if (e.st == STATUS_HIT)
					hits_seen++;
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					errors++;
				end
				if (hit_target !== e.target) begin
					$display("%0t: hit_target expected %0d actual %0d",
						$time, e.target, hit_target);
					errors++;
				end
				if (hit_index !== e.index) begin
					$display("%0t: hit_index expected %0d actual %0d",
						$time, e.index, hit_index);
					errors++;
				end
				if (overflow !== e.ovf) begin
					$display("%0t: overflow expected %0d actual %0d",
						$time, e.ovf, overflow);
					errors++;
				end
			end
		end
	end

	function automatic logic [15:0] near(int span);
		if (span >= 32767)
			return 16'($urandom_range(0, 65535));
		return 16'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic logic [15:0] rand16();
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic test_rectangles();
		send_item(MODE_CLEAR, 0, 0);
		send_item(MODE_RECT, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 0, 16'hffff);
		send_item(MODE_QUERY, 16'h8000, 16'h7fff);
		send_item(MODE_CLEAR, 0, 0);
		send_item(MODE_RECT, 10, 20, -5, 3, 0, 16'h1234);
		send_item(MODE_QUERY, -5, 20);
		send_item(MODE_QUERY, 11, 5);
		send_item(MODE_SPARE_LO, 0, 0);
		send_item(MODE_SPARE_HI, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
	endtask

	task automatic test_circles();
		send_item(MODE_CIRC, 100, 100, 0, 0, 16'h8000, 16'h00aa);
		send_item(MODE_QUERY, 16'h8000, 16'h8000);
		send_item(MODE_CIRC, 16'h7fff, 0, 0, 0, -5, 7);
		send_item(MODE_QUERY, 16'h7ffc, 4);
	endtask

	task automatic test_polygons();
		send_item(MODE_CLEAR, 0, 0);
		send_item(MODE_VERTEX, 1, 1);
		// Diamond starting on its left tip to exercise the wrap-around crossing.
		send_item(MODE_POLY, 0, 0, 0, 0, 0, 16'd31);
		send_item(MODE_VERTEX, 0, 5);
		send_item(MODE_VERTEX, 5, 0);
		send_item(MODE_VERTEX, 5, 0);
		send_item(MODE_VERTEX, 10, 5);
		send_item(MODE_VERTEX, 5, 10);
		send_item(MODE_QUERY, -3, 5);
		send_item(MODE_QUERY, 5, 5);
		send_item(MODE_QUERY, 0, 5);
		send_item(MODE_POLY, 0, 0, 0, 0, 0, 16'd32);
		send_item(MODE_VERTEX, 40, 40);
		send_item(MODE_QUERY, 40, 40);
		send_item(MODE_POLY, 0, 0, 0, 0, 0, 16'd33);
		send_item(MODE_VERTEX, 20, 0);
		send_item(MODE_VERTEX, 30, 0);
		send_item(MODE_VERTEX, 30, 10);
		send_item(MODE_VERTEX, 20, 0);
		send_item(MODE_QUERY, 25, 0);
		send_item(MODE_QUERY, 30, 7);
		send_item(MODE_QUERY, 25, 5);
	endtask

	task automatic test_defaults();
		drain();
		write_reg(REG_DEFAULT_TARGET, 16'hffff);
		write_reg(REG_DEFAULT_ENABLED, 16'd1);
		send_item(MODE_QUERY, 16'h7fff, 16'h7fff);
		drain();
		write_reg(REG_DEFAULT_TARGET, 16'h0000);
		send_item(MODE_QUERY, 16'h8000, 16'h7fff);
		drain();
		write_reg(REG_DEFAULT_ENABLED, 16'd0);
	endtask

	task automatic test_table_limits();
		send_item(MODE_CLEAR, 0, 0);
		for (int i = 0; i < N_REGIONS; i++)
			send_item(MODE_RECT, 16'(i), 0, 16'(i), 0, 0, 16'(i + 500));
		send_item(MODE_POLY, 0, 0, 0, 0, 0, 1);
		send_item(MODE_VERTEX, 3, 3);
		send_item(MODE_QUERY, 63, 0);
		send_item(MODE_QUERY, 200, 0);
		send_item(MODE_CLEAR, 0, 0);
		send_item(MODE_QUERY, 0, 0);
		send_item(MODE_POLY, 0, 0, 0, 0, 0, 16'd9);
		for (int i = 0; i <= N_VERTICES; i++)
			send_item(MODE_VERTEX, 16'(i), 16'((i % 2) * 5));
		send_item(MODE_QUERY, 1000, 1000);
		send_item(MODE_CLEAR, 0, 0);
	endtask

	// Builds a small random map, then probes points around it.
	task automatic random_map_phase();
		int span, nreg, nv, nq, pick;
		logic [15:0] vx, vy, fx, fy;
		pick = $urandom_range(0, 9);
		span = pick < 4 ? 6 : pick < 7 ? 40 : pick < 9 ? 3000 : 32767;
		if ($urandom_range(0, 3) != 0)
			send_item(MODE_CLEAR, 0, 0);
		nreg = $urandom_range(1, 6);
		for (int r = 0; r < nreg; r++) begin
			case ($urandom_range(0, 2))
				0: send_item(MODE_RECT, near(span), near(span), near(span), near(span),
					near(span), rand16());
				1: send_item(MODE_CIRC, near(span), near(span), 0, 0, near(span),
					rand16());
				default: begin
					send_item(MODE_POLY, 0, 0, 0, 0, 0, rand16());
					nv = $urandom_range(1, 8);
					fx = near(span);
					fy = near(span);
					vx = fx;
					vy = fy;
					for (int v = 0; v < nv; v++) begin
						if (v == 0 || $urandom_range(0, 7) != 0) begin
							vx = near(span);
							vy = (v == 0 || $urandom_range(0, 2) != 0) ? near(span) : vy;
						end
						if (v == 0) begin
							fx = vx;
							fy = vy;
						end
						send_item(MODE_VERTEX, vx, vy);
					end
					if ($urandom_range(0, 3) == 0)
						send_item(MODE_VERTEX, fx, fy);
				end
			endcase
			if ($urandom_range(0, 9) == 0)
				send_item(3'($urandom_range(0, 7)), rand16(), rand16(), rand16(),
					rand16(), rand16(), rand16());
		end
		nq = $urandom_range(4, 14);
		for (int q = 0; q < nq; q++)
			send_item(MODE_QUERY, near(span), near(span));
	endtask

	task automatic test_random_maps();
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0) begin
				drain();
				write_reg(REG_DEFAULT_TARGET, rand16());
				write_reg(REG_DEFAULT_ENABLED, 16'($urandom_range(0, 1)));
			end
			random_map_phase();
			phases++;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_rectangles();
		test_circles();
		test_polygons();
		test_defaults();
		test_table_limits();
		test_random_maps();
		drain();
		$display("%0d transactions sent, %0d map phases, %0d query results checked (%0d hits)",
			items_sent, phases, checked, hits_seen);
		if (errors == 0 && pending_hits.size() == 0)
			$display("tb_image_map_region_hit_test_unit OK");
		else
			$display("tb_image_map_region_hit_test_unit NOT OK");
		$finish;
	end

endmodule
